/* src/nca_pkg.sv */
// Shared constants, command and status types for the node cell adjacency store.
package nca_pkg;

    localparam int NODES_DEF    = 1024;
    localparam int SLOTS_DEF    = 8192;
    localparam int MAX_LIST_DEF = 64;

    localparam int NODE_W    = 10;
    localparam int NODE_SPAN = 1 << NODE_W;
    localparam int CELL_W    = 16;
    localparam int CNT_W     = 12;
    localparam int CNT_MAX   = 4095;

    localparam logic [2:0] K_REG    = 3'd0;
    localparam logic [2:0] K_REMOVE = 3'd1;
    localparam logic [2:0] K_EXISTS = 3'd2;
    localparam logic [2:0] K_DEGREE = 3'd3;
    localparam logic [2:0] K_LIST   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef enum logic [2:0] {
        CUR_KEEP,
        CUR_HEAD,
        CUR_END,
        CUR_LINK,
        CUR_NEXT
    } cur_sel_t;

    typedef enum logic [1:0] {
        RA_CUR,
        RA_ZERO,
        RA_ENTRY,
        RA_TERM
    } rd_sel_t;

    typedef enum logic [2:0] {
        WA_NONE,
        WA_TERM,
        WA_ENTRY,
        WA_ZERO,
        WA_HIT
    } wr_sel_t;

    typedef struct packed {
        logic       ld_req;
        logic       clr_step;
        logic       init_walk;
        logic       head_rd;
        logic       head_wr;
        cur_sel_t   cur_sel;
        logic       st_rd;
        rd_sel_t    rd_sel;
        wr_sel_t    wr_sel;
        logic       cap_head;
        logic       cap_entry;
        logic       cap_free;
        logic       n_inc;
        logic       hit_cap;
        logic       pend_cap;
        logic       out_push;
        logic [1:0] out_status;
        logic       out_found;
        logic       out_cnt;
        logic       out_cell;
        logic       out_trunc;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       out_free;
        logic       node_ok;
        logic [2:0] kind;
        logic       fix;
        logic       val_neg;
        logic       val_zero;
        logic       val_pos;
        logic       link_ok;
        logic       hops_max;
        logic       at_end;
        logic       n_lim;
        logic       n_zero;
        logic       match;
        logic       avail_ok;
        logic       hit_vld;
        logic       pend_vld;
    } sts_t;

endpackage

/* src/nca_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module nca_ram #(
    parameter int W = 18,
    parameter int D = 8192
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [$clog2(D)-1:0] wr_addr,
    input  logic [W-1:0]         wr_data,
    input  logic                 rd_en,
    input  logic [$clog2(D)-1:0] rd_addr,
    output logic [W-1:0]         rd_data
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/nca_ctrl.sv */
// Controller state machine: sequences clearing, register steps and list walks.
module nca_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  nca_pkg::sts_t sts,
    output nca_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_HRD,
        S_HWT,
        S_SRD,
        S_SCHK,
        S_RG0,
        S_RG1,
        S_RG2,
        S_RG3,
        S_RG4,
        S_RG5,
        S_RG6,
        S_RG7,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic       cnt;
        logic       cell_sel;
        logic       trunc;
    } fin_t;

    state_t state_reg, state_next;
    fin_t   fin_reg, fin_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.cur_sel    = nca_pkg::CUR_KEEP;
        cmd.rd_sel     = nca_pkg::RA_CUR;
        cmd.wr_sel     = nca_pkg::WA_NONE;
        state_next     = state_reg;
        fin_next       = fin_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_req = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.init_walk = 1'b1;
                fin_next      = '0;
                case (sts.kind) inside
                    nca_pkg::K_REG:
                    begin
                        state_next = S_RG0;
                    end
                    nca_pkg::K_REMOVE, nca_pkg::K_EXISTS, nca_pkg::K_DEGREE,
                    nca_pkg::K_LIST:
                    begin
                        if (sts.node_ok)
                        begin
                            state_next = S_HRD;
                        end
                        else
                        begin
                            cmd.cur_sel = nca_pkg::CUR_END;
                            state_next  = S_SRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_HRD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_HWT;
            end
            S_HWT:
            begin
                cmd.cur_sel = nca_pkg::CUR_HEAD;
                state_next  = S_SRD;
            end
            S_SRD:
            begin
                cmd.st_rd  = 1'b1;
                cmd.rd_sel = nca_pkg::RA_CUR;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (sts.val_neg && !sts.fix)
                begin
                    // Follow the skip link unless it leaves the store or the hop budget is spent.
                    cmd.cur_sel = (sts.hops_max || !sts.link_ok) ? nca_pkg::CUR_END
                                                                 : nca_pkg::CUR_LINK;
                    state_next  = S_SRD;
                end
                else if (sts.val_pos && !sts.n_lim)
                begin
                    if (!(sts.kind == nca_pkg::K_LIST && sts.pend_vld && !sts.out_free))
                    begin
                        cmd.n_inc   = 1'b1;
                        cmd.cur_sel = sts.at_end ? nca_pkg::CUR_END : nca_pkg::CUR_NEXT;
                        state_next  = S_SRD;
                        case (sts.kind)
                            nca_pkg::K_REMOVE:
                            begin
                                cmd.hit_cap = sts.match;
                            end
                            nca_pkg::K_EXISTS:
                            begin
                                if (sts.match)
                                begin
                                    cmd.cur_sel    = nca_pkg::CUR_KEEP;
                                    fin_next.found = 1'b1;
                                    state_next     = S_EMIT;
                                end
                            end
                            nca_pkg::K_LIST:
                            begin
                                // The previous cell goes out now; the newest one waits
                                // until it is known whether it is the final one.
                                cmd.pend_cap = 1'b1;
                                if (sts.pend_vld)
                                begin
                                    cmd.out_push  = 1'b1;
                                    cmd.out_found = 1'b1;
                                    cmd.out_cell  = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                    case (sts.kind)
                        nca_pkg::K_REMOVE:
                        begin
                            if (sts.hit_vld)
                            begin
                                cmd.wr_sel = nca_pkg::WA_HIT;
                            end
                            else
                            begin
                                fin_next.status = nca_pkg::ST_MISS;
                            end
                        end
                        nca_pkg::K_DEGREE:
                        begin
                            fin_next.cnt = 1'b1;
                        end
                        nca_pkg::K_LIST:
                        begin
                            if (!sts.n_zero)
                            begin
                                fin_next.found    = 1'b1;
                                fin_next.cell_sel = 1'b1;
                                fin_next.trunc    = sts.val_pos;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RG0:
            begin
                cmd.st_rd   = 1'b1;
                cmd.rd_sel  = nca_pkg::RA_ZERO;
                cmd.head_rd = 1'b1;
                state_next  = S_RG1;
            end
            S_RG1:
            begin
                cmd.cap_head  = 1'b1;
                cmd.cap_entry = 1'b1;
                if (sts.node_ok && sts.avail_ok)
                begin
                    state_next = S_RG2;
                end
                else
                begin
                    fin_next.status = nca_pkg::ST_FULL;
                    state_next      = S_EMIT;
                end
            end
            S_RG2:
            begin
                cmd.st_rd  = 1'b1;
                cmd.rd_sel = nca_pkg::RA_ENTRY;
                state_next = S_RG3;
            end
            S_RG3:
            begin
                if (sts.val_zero)
                begin
                    fin_next.status = nca_pkg::ST_FULL;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_RG4;
                end
            end
            S_RG4:
            begin
                cmd.st_rd  = 1'b1;
                cmd.rd_sel = nca_pkg::RA_TERM;
                state_next = S_RG5;
            end
            S_RG5:
            begin
                cmd.cap_free = 1'b1;
                cmd.wr_sel   = nca_pkg::WA_TERM;
                state_next   = S_RG6;
            end
            S_RG6:
            begin
                cmd.wr_sel  = nca_pkg::WA_ENTRY;
                cmd.head_wr = 1'b1;
                state_next  = S_RG7;
            end
            S_RG7:
            begin
                cmd.wr_sel = nca_pkg::WA_ZERO;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_push   = 1'b1;
                    cmd.out_status = fin_reg.status;
                    cmd.out_found  = fin_reg.found;
                    cmd.out_cnt    = fin_reg.cnt;
                    cmd.out_cell   = fin_reg.cell_sel;
                    cmd.out_trunc  = fin_reg.trunc;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            fin_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

/* src/nca_dp.sv */
// Datapath: head and slot stores, walk registers and the output register.
module nca_dp #(
    parameter int NODES    = nca_pkg::NODES_DEF,
    parameter int SLOTS    = nca_pkg::SLOTS_DEF,
    parameter int MAX_LIST = nca_pkg::MAX_LIST_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [2:0]                  kind,
    input  logic [nca_pkg::NODE_W-1:0]  node,
    input  logic [nca_pkg::CELL_W-1:0]  cell_req,
    input  nca_pkg::cmd_t               cmd,
    output nca_pkg::sts_t               sts,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic                        found,
    output logic [nca_pkg::CNT_W-1:0]   count,
    output logic [nca_pkg::CELL_W-1:0]  cell_out,
    output logic                        truncated,
    output logic                        last
);

    localparam int SW      = $clog2(SLOTS);
    localparam int DW      = (SW + 1 > 18) ? SW + 1 : 18;
    localparam int HD      = (NODES < nca_pkg::NODE_SPAN) ? NODES : nca_pkg::NODE_SPAN;
    localparam int HAW     = $clog2(HD);
    localparam int CLR_LEN = (SLOTS > HD) ? SLOTS : HD;
    localparam int CW      = $clog2(CLR_LEN);
    localparam logic [SW-1:0]        END_SLOT  = SW'(SLOTS - 1);
    localparam logic signed [DW-1:0] AVAIL_MIN = DW'(-(SLOTS - 3));

    logic [2:0]                 kind_reg;
    logic [nca_pkg::NODE_W-1:0] node_reg;
    logic [nca_pkg::CELL_W-1:0] cell_reg;
    logic [SW-1:0]              cur_reg;
    logic                       fix_reg;
    logic [SW:0]                hops_reg;
    logic [SW:0]                n_reg;
    logic [SW-1:0]              hit_reg;
    logic                       hit_vld_reg;
    logic [nca_pkg::CELL_W-1:0] pend_reg;
    logic                       pend_vld_reg;
    logic [SW-1:0]              head_old_reg;
    logic [SW-1:0]              entry_reg;
    logic [DW-1:0]              free_reg;
    logic [CW-1:0]              clr_cnt_reg;

    logic                       out_valid_reg;
    logic [1:0]                 status_reg;
    logic                       found_reg;
    logic [nca_pkg::CNT_W-1:0]  count_reg;
    logic [nca_pkg::CELL_W-1:0] cell_out_reg;
    logic                       truncated_reg;
    logic                       last_reg;

    logic [DW-1:0]        rd_data;
    logic signed [DW-1:0] val;
    logic signed [DW:0]   neg;
    logic [SW-1:0]        head_rd_data;
    logic [SW-1:0]        term;
    logic [DW-1:0]        cell_p1;
    logic [31:0]          n32;
    logic [31:0]          limit;
    logic [nca_pkg::CNT_W-1:0] n_sat;

    logic                 st_we;
    logic [SW-1:0]        st_waddr;
    logic [DW-1:0]        st_wdata;
    logic [SW-1:0]        st_raddr;
    logic                 hd_we;
    logic [HAW-1:0]       hd_waddr;
    logic [SW-1:0]        hd_wdata;

    assign val     = $signed(rd_data);
    assign neg     = -$signed({rd_data[DW-1], rd_data});
    assign term    = entry_reg + SW'(1);
    assign cell_p1 = DW'(cell_reg) + DW'(1);
    assign n32     = 32'(n_reg);
    assign limit   = (kind_reg == nca_pkg::K_LIST) ? 32'(MAX_LIST) : 32'(SLOTS);
    assign n_sat   = (n32 > 32'(nca_pkg::CNT_MAX)) ? nca_pkg::CNT_W'(nca_pkg::CNT_MAX)
                                                   : n32[nca_pkg::CNT_W-1:0];

    always_comb
    begin
        sts          = '0;
        sts.clr_last = (32'(clr_cnt_reg) == CLR_LEN - 1);
        sts.out_free = !out_valid_reg || !out_stall;
        sts.node_ok  = (32'(node_reg) < NODES);
        sts.kind     = kind_reg;
        sts.fix      = fix_reg;
        sts.val_neg  = val < 0;
        sts.val_zero = (rd_data == '0);
        sts.val_pos  = val > 0;
        sts.link_ok  = neg < $signed((DW + 1)'(SLOTS));
        sts.hops_max = (32'(hops_reg) >= SLOTS);
        sts.at_end   = (cur_reg == END_SLOT);
        sts.n_lim    = (n32 >= limit);
        sts.n_zero   = (n_reg == '0);
        sts.match    = (rd_data == cell_p1);
        sts.avail_ok = (val < 0) && (val >= AVAIL_MIN);
        sts.hit_vld  = hit_vld_reg;
        sts.pend_vld = pend_vld_reg;
    end

    // Slot store ports.
    always_comb
    begin
        case (cmd.rd_sel)
            nca_pkg::RA_ZERO:  st_raddr = '0;
            nca_pkg::RA_ENTRY: st_raddr = entry_reg;
            nca_pkg::RA_TERM:  st_raddr = term;
            default:           st_raddr = cur_reg;
        endcase
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = '0;
        if (cmd.clr_step)
        begin
            st_we    = (32'(clr_cnt_reg) < SLOTS);
            st_waddr = clr_cnt_reg[SW-1:0];
            st_wdata = (32'(clr_cnt_reg) == SLOTS - 1) ? '0
                                                       : -(DW'(clr_cnt_reg) + DW'(1));
        end
        else
        begin
            case (cmd.wr_sel)
                nca_pkg::WA_TERM:
                begin
                    st_we    = 1'b1;
                    st_waddr = term;
                    st_wdata = -DW'(head_old_reg);
                end
                nca_pkg::WA_ENTRY:
                begin
                    st_we    = 1'b1;
                    st_waddr = entry_reg;
                    st_wdata = cell_p1;
                end
                nca_pkg::WA_ZERO:
                begin
                    st_we    = 1'b1;
                    st_waddr = '0;
                    st_wdata = free_reg;
                end
                nca_pkg::WA_HIT:
                begin
                    st_we    = 1'b1;
                    st_waddr = hit_reg;
                    st_wdata = -(DW'(hit_reg) + DW'(1));
                end
                default:
                begin
                end
            endcase
        end
    end

    // Head store ports.
    always_comb
    begin
        if (cmd.clr_step)
        begin
            hd_we    = (32'(clr_cnt_reg) < HD);
            hd_waddr = clr_cnt_reg[HAW-1:0];
            hd_wdata = END_SLOT;
        end
        else
        begin
            hd_we    = cmd.head_wr;
            hd_waddr = node_reg[HAW-1:0];
            hd_wdata = entry_reg;
        end
    end

    nca_ram #(
        .W (DW),
        .D (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_en   (cmd.st_rd),
        .rd_addr (st_raddr),
        .rd_data (rd_data)
    );

    nca_ram #(
        .W (SW),
        .D (HD)
    ) u_head_ram (
        .clk     (clk),
        .wr_en   (hd_we),
        .wr_addr (hd_waddr),
        .wr_data (hd_wdata),
        .rd_en   (cmd.head_rd),
        .rd_addr (node_reg[HAW-1:0]),
        .rd_data (head_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.ld_req)
        begin
            kind_reg <= kind;
            node_reg <= node;
            cell_reg <= cell_req;
        end
        case (cmd.cur_sel)
            nca_pkg::CUR_HEAD:
            begin
                cur_reg  <= head_rd_data;
                fix_reg  <= 1'b0;
                hops_reg <= '0;
            end
            nca_pkg::CUR_END:
            begin
                cur_reg <= END_SLOT;
                fix_reg <= 1'b1;
            end
            nca_pkg::CUR_LINK:
            begin
                cur_reg  <= neg[SW-1:0];
                hops_reg <= hops_reg + (SW + 1)'(1);
            end
            nca_pkg::CUR_NEXT:
            begin
                cur_reg  <= cur_reg + SW'(1);
                fix_reg  <= 1'b0;
                hops_reg <= '0;
            end
            default:
            begin
            end
        endcase
        if (cmd.hit_cap)
        begin
            hit_reg <= cur_reg;
        end
        if (cmd.pend_cap)
        begin
            pend_reg <= rd_data[nca_pkg::CELL_W-1:0] - nca_pkg::CELL_W'(1);
        end
        if (cmd.cap_head)
        begin
            head_old_reg <= head_rd_data;
        end
        if (cmd.cap_entry)
        begin
            entry_reg <= neg[SW-1:0];
        end
        if (cmd.cap_free)
        begin
            free_reg <= (rd_data == '0) ? -DW'(term) : rd_data;
        end
        if (cmd.out_push)
        begin
            status_reg    <= cmd.out_status;
            found_reg     <= cmd.out_found;
            count_reg     <= cmd.out_cnt ? n_sat : '0;
            cell_out_reg  <= cmd.out_cell ? pend_reg : '0;
            truncated_reg <= cmd.out_trunc;
            last_reg      <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            n_reg         <= '0;
            hit_vld_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            if (cmd.init_walk)
            begin
                n_reg        <= '0;
                hit_vld_reg  <= 1'b0;
                pend_vld_reg <= 1'b0;
            end
            else
            begin
                if (cmd.n_inc)
                begin
                    n_reg <= n_reg + (SW + 1)'(1);
                end
                if (cmd.hit_cap)
                begin
                    hit_vld_reg <= 1'b1;
                end
                if (cmd.pend_cap)
                begin
                    pend_vld_reg <= 1'b1;
                end
            end
            if (cmd.out_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign count     = count_reg;
    assign cell_out  = cell_out_reg;
    assign truncated = truncated_reg;
    assign last      = last_reg;

endmodule

/* src/node_cell_adjacency_store_core.sv */
// Top level of the node cell adjacency store: controller plus datapath.
//
//   Channel   Signals                                  Moves per transfer
//   input     in_valid / in_stall, kind node cell_req  one request
//   output    out_valid / out_stall, status found      one result; list gives up to
//             count cell_out truncated last            MAX_LIST results, last marked
//
// A register request ends early when the store is full. Remove, exists, degree
// and list walk the node's slots, with one read of the slot RAM for every slot
// visited, cell or skip link.
// After reset the block sweeps both stores, with in_stall high throughout.
// A stalled output holds the walk; no new request is taken until the last
// result of the current one is in the output register.
module node_cell_adjacency_store_core #(
    parameter int NODES    = nca_pkg::NODES_DEF,
    parameter int SLOTS    = nca_pkg::SLOTS_DEF,
    parameter int MAX_LIST = nca_pkg::MAX_LIST_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  kind,
    input  logic [nca_pkg::NODE_W-1:0]  node,
    input  logic [nca_pkg::CELL_W-1:0]  cell_req,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic                        found,
    output logic [nca_pkg::CNT_W-1:0]   count,
    output logic [nca_pkg::CELL_W-1:0]  cell_out,
    output logic                        truncated,
    output logic                        last
);

    nca_pkg::cmd_t cmd;
    nca_pkg::sts_t sts;

    nca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    nca_dp #(
        .NODES    (NODES),
        .SLOTS    (SLOTS),
        .MAX_LIST (MAX_LIST)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .kind      (kind),
        .node      (node),
        .cell_req  (cell_req),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .found     (found),
        .count     (count),
        .cell_out  (cell_out),
        .truncated (truncated),
        .last      (last)
    );

endmodule
